// ===== hw/rtl/generational_slot_allocator_core_defines.svh =====
// Assertion macros used by the checker file gsa_checker.sv.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GSA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GSA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gsa_pkg.sv =====
package gsa_pkg;

    localparam int IDX_FW = 12;
    localparam int GEN_FW = 16;
    localparam int ST_W   = 2;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_UNLOAD = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;

    localparam logic [ST_W-1:0] ST_NOT_LOADED = 2'd0;
    localparam logic [ST_W-1:0] ST_LOADING    = 2'd1;
    localparam logic [ST_W-1:0] ST_READY      = 2'd2;
    localparam logic [ST_W-1:0] ST_FAILED     = 2'd3;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_STALE = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_FW-1:0] slot_index;
        logic [GEN_FW-1:0] slot_generation;
        logic              load_ok;
    } req_t;

    typedef struct packed {
        logic [IDX_FW-1:0] out_index;
        logic [GEN_FW-1:0] out_generation;
        logic [1:0]        status;
        logic [ST_W-1:0]   slot_state;
    } rsp_t;

endpackage

// ===== hw/rtl/gsa_ram.sv =====
module gsa_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 18,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/generational_slot_allocator_core.sv =====
// Generational slot allocator. Handles are (index, generation) pairs; each slot keeps a
// generation and a load state in one single-port-read memory, and freed indices sit on a
// LIFO stack in a second memory. One transaction is in flight at a time: query, unload,
// finish and alloc of a never-used index go from acceptance straight to S_SLOT, alloc
// from the free stack passes through S_STACK first, because the stack read must return
// before the slot entry can be read (each memory has a registered read port). The
// result sits in an output register, so a new transaction is accepted while the previous
// result waits; a stalled result holds back only the completion of the next one. No
// clearing pass follows reset: entries at or above the in-use mark are never read as
// live, so a fresh index is treated as generation 0, not loaded.
module generational_slot_allocator_core #(
    parameter int SLOT_COUNT     = 4096,
    parameter int MAX_GENERATION = 65535
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  gsa_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output gsa_pkg::rsp_t m_data
);

    localparam int IDX_FW = gsa_pkg::IDX_FW;
    localparam int GEN_W  = gsa_pkg::GEN_FW;
    localparam int ST_W   = gsa_pkg::ST_W;
    localparam int SLOT_W = GEN_W + ST_W;
    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int CMP_W  = (CNT_W > IDX_FW + 1) ? CNT_W : IDX_FW + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_STACK = 2'd1;
    localparam logic [1:0] S_SLOT  = 2'd2;

    logic [1:0]       state_reg, state_next;
    gsa_pkg::req_t    req_reg, req_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic             fresh_reg, fresh_next;
    logic             full_reg, full_next;
    logic             in_range_reg, in_range_next;
    logic [CNT_W-1:0] free_count_reg, free_count_next;
    logic [CNT_W-1:0] mark_reg, mark_next;
    logic             m_valid_reg, m_valid_next;
    gsa_pkg::rsp_t    m_data_reg, m_data_next;

    logic              slot_wr_en, slot_rd_en;
    logic [IDX_W-1:0]  slot_rd_addr;
    logic [SLOT_W-1:0] slot_wr_data, slot_rd_data;
    logic              stk_wr_en, stk_rd_en;
    logic [IDX_W-1:0]  stk_wr_addr, stk_rd_addr, stk_rd_data;

    logic [CMP_W-1:0] idx_ext, slot_ext;
    logic [CNT_W-1:0] count_dec;
    logic [GEN_W-1:0] gen_rd, gen_cur, gen_alloc, gen_bump;
    logic [ST_W-1:0]  st_rd, st_fin;
    logic             live, complete;

    gsa_ram #(.DEPTH(SLOT_COUNT), .WIDTH(SLOT_W)) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_reg),
        .wr_data (slot_wr_data),
        .rd_en   (slot_rd_en),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd_data)
    );

    gsa_ram #(.DEPTH(SLOT_COUNT), .WIDTH(IDX_W)) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (slot_reg),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign complete = (state_reg == S_SLOT) && (!m_valid_reg || m_ready);

    assign idx_ext   = CMP_W'(s_data.slot_index);
    assign slot_ext  = CMP_W'(slot_reg);
    assign count_dec = free_count_reg - CNT_W'(1);

    assign gen_rd    = slot_rd_data[SLOT_W-1:ST_W];
    assign st_rd     = slot_rd_data[ST_W-1:0];
    // a never-used index holds whatever the memory powered up with
    assign gen_cur   = fresh_reg ? '0 : gen_rd;
    assign gen_alloc = (gen_cur == '0) ? GEN_W'(1) : gen_cur;
    assign gen_bump  = (gen_rd >= GEN_W'(MAX_GENERATION)) ? GEN_W'(1) : gen_rd + GEN_W'(1);
    assign st_fin    = req_reg.load_ok ? gsa_pkg::ST_READY : gsa_pkg::ST_FAILED;
    assign live      = (req_reg.slot_generation != '0) && in_range_reg &&
                       (gen_rd == req_reg.slot_generation) &&
                       (st_rd != gsa_pkg::ST_NOT_LOADED);

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        slot_next       = slot_reg;
        fresh_next      = fresh_reg;
        full_next       = full_reg;
        in_range_next   = in_range_reg;
        free_count_next = free_count_reg;
        mark_next       = mark_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        slot_rd_en      = 1'b0;
        slot_rd_addr    = slot_reg;
        slot_wr_en      = 1'b0;
        slot_wr_data    = '0;
        stk_rd_en       = 1'b0;
        stk_rd_addr     = count_dec[IDX_W-1:0];
        stk_wr_en       = 1'b0;
        stk_wr_addr     = free_count_reg[IDX_W-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next      = s_data;
                    fresh_next    = 1'b0;
                    full_next     = 1'b0;
                    in_range_next = idx_ext < CMP_W'(mark_reg);
                    state_next    = S_SLOT;
                    if (s_data.op == gsa_pkg::OP_ALLOC) begin
                        if (free_count_reg != '0) begin
                            stk_rd_en  = 1'b1;
                            state_next = S_STACK;
                        end else if (mark_reg < CNT_W'(SLOT_COUNT)) begin
                            slot_next  = mark_reg[IDX_W-1:0];
                            fresh_next = 1'b1;
                        end else begin
                            full_next = 1'b1;
                        end
                    end else begin
                        slot_next    = idx_ext[IDX_W-1:0];
                        slot_rd_en   = 1'b1;
                        slot_rd_addr = idx_ext[IDX_W-1:0];
                    end
                end
            end
            S_STACK: begin
                slot_next    = stk_rd_data;
                slot_rd_en   = 1'b1;
                slot_rd_addr = stk_rd_data;
                state_next   = S_SLOT;
            end
            S_SLOT: begin
                if (complete) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_index: req_reg.slot_index, out_generation: '0,
                                     status: gsa_pkg::STATUS_STALE,
                                     slot_state: gsa_pkg::ST_NOT_LOADED};
                    case (req_reg.op)
                        gsa_pkg::OP_ALLOC: begin
                            if (full_reg) begin
                                m_data_next = '{out_index: '0, out_generation: '0,
                                                status: gsa_pkg::STATUS_FULL,
                                                slot_state: gsa_pkg::ST_NOT_LOADED};
                            end else begin
                                slot_wr_en   = 1'b1;
                                slot_wr_data = {gen_alloc, gsa_pkg::ST_LOADING};
                                m_data_next  = '{out_index: slot_ext[IDX_FW-1:0],
                                                 out_generation: gen_alloc,
                                                 status: gsa_pkg::STATUS_DONE,
                                                 slot_state: gsa_pkg::ST_LOADING};
                                if (fresh_reg) begin
                                    mark_next = mark_reg + CNT_W'(1);
                                end else begin
                                    free_count_next = count_dec;
                                end
                            end
                        end
                        gsa_pkg::OP_UNLOAD: begin
                            if (live) begin
                                slot_wr_en   = 1'b1;
                                slot_wr_data = {gen_bump, gsa_pkg::ST_NOT_LOADED};
                                m_data_next.status = gsa_pkg::STATUS_DONE;
                                if (free_count_reg < CNT_W'(SLOT_COUNT)) begin
                                    stk_wr_en       = 1'b1;
                                    free_count_next = free_count_reg + CNT_W'(1);
                                end
                            end
                        end
                        gsa_pkg::OP_QUERY: begin
                            if (live) begin
                                m_data_next.status     = gsa_pkg::STATUS_DONE;
                                m_data_next.slot_state = st_rd;
                            end
                        end
                        default: begin
                            if (in_range_reg && st_rd != gsa_pkg::ST_NOT_LOADED) begin
                                slot_wr_en   = 1'b1;
                                slot_wr_data = {gen_rd, st_fin};
                                m_data_next.status     = gsa_pkg::STATUS_DONE;
                                m_data_next.slot_state = st_fin;
                            end
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            free_count_reg <= '0;
            mark_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            mark_reg       <= mark_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        slot_reg     <= slot_next;
        fresh_reg    <= fresh_next;
        full_reg     <= full_next;
        in_range_reg <= in_range_next;
        m_data_reg   <= m_data_next;
    end

endmodule

// ===== hw/rtl/gsa_checker.sv =====
`include "generational_slot_allocator_core_defines.svh"

module gsa_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input gsa_pkg::req_t s_data,
    input logic          m_valid,
    input logic          m_ready,
    input gsa_pkg::rsp_t m_data
);

    // a waiting input transaction is held by the sender
    `GSA_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_data), "input dropped or changed while waiting")

    // a stalled result stays put
    `GSA_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result dropped or changed while stalled")

    // pool full carries no handle
    `GSA_ASSERT_NOW(a_full, aclk, aresetn, m_valid && m_data.status == gsa_pkg::STATUS_FULL, m_data.out_index == '0 && m_data.out_generation == '0 && m_data.slot_state == gsa_pkg::ST_NOT_LOADED, "full result carries data")

    // only a successful alloc returns a generation
    `GSA_ASSERT_NOW(a_gen, aclk, aresetn, m_valid && m_data.out_generation != '0, m_data.status == gsa_pkg::STATUS_DONE && m_data.slot_state == gsa_pkg::ST_LOADING, "generation on a non-alloc result")

    `GSA_ASSERT_NOW(a_stale, aclk, aresetn, m_valid && m_data.status == gsa_pkg::STATUS_STALE, m_data.slot_state == gsa_pkg::ST_NOT_LOADED && m_data.out_generation == '0, "stale result carries state")

endmodule

bind generational_slot_allocator_core gsa_checker u_gsa_checker (.*);

// ===== bench/slot_allocator_checker.sv =====
module slot_allocator_checker
    import gsa_pkg::*;
#(
    parameter int SLOT_COUNT     = 4096,
    parameter int MAX_GENERATION = 65535
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  req_t s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  rsp_t m_data,
    output int   fail_count,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [GEN_FW-1:0] gen_mem   [SLOT_COUNT];
    logic [ST_W-1:0]   state_mem [SLOT_COUNT];
    logic [IDX_FW-1:0] free_lifo [SLOT_COUNT];
    int unsigned       free_depth;
    int unsigned       high_water;   // indices ever handed out
    rsp_t              replies_due [$];

    // Live means nonzero generation, index already handed out, generation matches
    // and the slot is not sitting on the free stack.
    function automatic bit holds_live_handle(logic [IDX_FW-1:0] idx, logic [GEN_FW-1:0] gen);
        return gen != '0 && idx < high_water && idx < SLOT_COUNT
            && gen_mem[idx] == gen && state_mem[idx] != ST_NOT_LOADED;
    endfunction

    function automatic rsp_t apply_slot_op(req_t r);
        rsp_t            res;
        int unsigned     slot;
        logic [ST_W-1:0] st;
        res.out_index      = r.slot_index;
        res.out_generation = '0;
        res.status         = STATUS_STALE;
        res.slot_state     = ST_NOT_LOADED;
        case (r.op)
            OP_ALLOC: begin
                if (free_depth > 0) begin
                    free_depth--;
                    slot = free_lifo[free_depth];
                end else if (high_water < SLOT_COUNT) begin
                    slot = high_water;
                    high_water++;
                end else begin
                    res.out_index = '0;
                    res.status    = STATUS_FULL;
                    return res;
                end
                if (gen_mem[slot] == '0) begin
                    gen_mem[slot] = GEN_FW'(1);
                end
                state_mem[slot]    = ST_LOADING;
                res.out_index      = IDX_FW'(slot);
                res.out_generation = gen_mem[slot];
                res.status         = STATUS_DONE;
                res.slot_state     = ST_LOADING;
            end
            OP_UNLOAD: begin
                if (holds_live_handle(r.slot_index, r.slot_generation)) begin
                    gen_mem[r.slot_index] =
                        GEN_FW'((int'(gen_mem[r.slot_index]) % MAX_GENERATION) + 1);
                    state_mem[r.slot_index] = ST_NOT_LOADED;
                    if (free_depth < SLOT_COUNT) begin
                        free_lifo[free_depth] = r.slot_index;
                        free_depth++;
                    end
                    res.status = STATUS_DONE;
                end
            end
            OP_QUERY: begin
                if (holds_live_handle(r.slot_index, r.slot_generation)) begin
                    res.status     = STATUS_DONE;
                    res.slot_state = state_mem[r.slot_index];
                end
            end
            OP_FINISH: begin
                // finish goes by index alone, generation is not checked
                if (r.slot_index < high_water && state_mem[r.slot_index] != ST_NOT_LOADED) begin
                    st = r.load_ok ? ST_READY : ST_FAILED;
                    state_mem[r.slot_index] = st;
                    res.status     = STATUS_DONE;
                    res.slot_state = st;
                end
            end
        endcase
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                gen_mem[i]   = '0;
                state_mem[i] = ST_NOT_LOADED;
            end
            free_depth = 0;
            high_water = 0;
            replies_due.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    $error("result transaction with nothing pending: %p", m_data);
                    fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("out_index", 32'(want.out_index), 32'(m_data.out_index));
                    check_field("out_generation", 32'(want.out_generation),
                                32'(m_data.out_generation));
                    check_field("status", 32'(want.status), 32'(m_data.status));
                    check_field("slot_state", 32'(want.slot_state), 32'(m_data.slot_state));
                end
            end
            if (s_valid && s_ready) begin
                replies_due.insert(replies_due.size(), apply_slot_op(s_data));
            end
        end
        outstanding = replies_due.size();
    end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gsa_pkg::*;

    localparam int SLOTS       = 4096;
    localparam int GEN_LIMIT   = 65535;
    localparam int HOLD_CYCLES = 200;
    localparam int POOL_CAP    = 48;

    typedef struct packed {
        logic [IDX_FW-1:0] idx;
        logic [GEN_FW-1:0] gen;
    } handle_t;

    logic    aclk = 1'b0;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    req_t    s_data;
    logic    m_valid;
    logic    m_ready = 1'b0;
    rsp_t    m_data;
    logic    req_taken = 1'b0;
    int      fail_count;
    int      outstanding;
    int      src_idle_pct = 9;
    int      snk_idle_pct = 88;
    logic    hold_go = 1'b0;
    int      hold_count = 0;
    handle_t live_handles [$];

    always #6 aclk = ~aclk;

    generational_slot_allocator_core #(
        .SLOT_COUNT     (SLOTS),
        .MAX_GENERATION (GEN_LIMIT)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    slot_allocator_checker #(
        .SLOT_COUNT     (SLOTS),
        .MAX_GENERATION (GEN_LIMIT)
    ) checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        req_taken <= s_valid && s_ready;
    end

    // Collect handles from successful allocs so later transactions can reuse them.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready && m_data.status == STATUS_DONE
            && m_data.out_generation != '0) begin
            live_handles.insert(live_handles.size(),
                                handle_t'{idx: m_data.out_index, gen: m_data.out_generation});
        end
    end

    // Receiver: random back-pressure, or a long hold-off while hold_go is up.
    always @(negedge aclk) begin
        if (hold_go && hold_count < HOLD_CYCLES) begin
            m_ready    <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            if (!hold_go) begin
                hold_count <= 0;
            end
            m_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin
        #4_000_000;
        $display("** generational_slot_allocator_core: FAILED **");
        $finish;
    end

    function automatic req_t slot_req(int unsigned op, int unsigned idx, int unsigned gen,
                                      int unsigned ok);
        req_t r;
        r.op              = 2'(op);
        r.slot_index      = IDX_FW'(idx);
        r.slot_generation = GEN_FW'(gen);
        r.load_ok         = 1'(ok);
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic push_req(input req_t r);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(negedge aclk); while (!req_taken);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
    endtask

    task automatic pick_req(output req_t r);
        int unsigned roll;
        int unsigned k;
        handle_t     h;
        r    = slot_req($urandom, $urandom, $urandom, $urandom);
        roll = $urandom_range(99);
        if (roll < 15) begin
            // junk handle, half of the time aimed at the low indices in use
            if (roll < 8) begin
                r.slot_index      = IDX_FW'($urandom_range(15));
                r.slot_generation = GEN_FW'($urandom_range(3));
            end
            return;
        end
        if (live_handles.size() == 0) begin
            r.op = OP_ALLOC;
            return;
        end
        k = $urandom_range(live_handles.size() - 1);
        h = live_handles[k];
        r.slot_index      = h.idx;
        r.slot_generation = h.gen;
        if (roll < 40) begin
            r.op = (live_handles.size() < POOL_CAP) ? OP_ALLOC : OP_UNLOAD;
        end else if (roll < 60) begin
            r.op = OP_UNLOAD;
        end else if (roll < 80) begin
            r.op = OP_QUERY;
            if (roll < 64) begin
                r.slot_generation = h.gen + 1'b1;
            end
        end else begin
            r.op = OP_FINISH;
        end
        if (r.op == OP_UNLOAD) begin
            live_handles.delete(k);
        end
    endtask

    task automatic run_random(int n);
        req_t r;
        repeat (n) begin
            pick_req(r);
            push_req(r);
        end
    endtask

    initial begin
        s_valid = 1'b0;
        s_data  = '0;
        aresetn = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // sender idles 9%, receiver 88%
        push_req(slot_req(OP_QUERY, 0, 0, 0));          // null handle
        push_req(slot_req(OP_FINISH, 0, 0, 1));         // index never handed out
        push_req(slot_req(OP_UNLOAD, 0, 1, 0));
        push_req(slot_req(OP_ALLOC, 0, 0, 0));
        push_req(slot_req(OP_ALLOC, 4095, 65535, 1));   // fields ignored by alloc
        push_req(slot_req(OP_QUERY, 0, 1, 0));
        push_req(slot_req(OP_QUERY, 0, 2, 0));          // wrong generation
        push_req(slot_req(OP_QUERY, 1, 0, 0));
        push_req(slot_req(OP_FINISH, 0, 0, 1));
        push_req(slot_req(OP_FINISH, 1, 0, 0));
        push_req(slot_req(OP_QUERY, 0, 1, 0));
        push_req(slot_req(OP_QUERY, 1, 1, 0));
        push_req(slot_req(OP_FINISH, 4095, 65535, 1));
        push_req(slot_req(OP_UNLOAD, 4095, 65535, 1));
        push_req(slot_req(OP_UNLOAD, 0, 1, 0));
        push_req(slot_req(OP_UNLOAD, 0, 1, 0));         // double free
        push_req(slot_req(OP_UNLOAD, 0, 2, 0));         // forged handle on a free slot
        push_req(slot_req(OP_QUERY, 0, 2, 0));
        push_req(slot_req(OP_FINISH, 0, 2, 1));         // finish on a free slot
        push_req(slot_req(OP_ALLOC, 0, 0, 0));          // reuses the freed index
        push_req(slot_req(OP_ALLOC, 0, 0, 0));
        push_req(slot_req(OP_UNLOAD, 1, 1, 0));
        push_req(slot_req(OP_UNLOAD, 2, 1, 0));
        push_req(slot_req(OP_ALLOC, 0, 0, 0));          // LIFO: index 2 first
        push_req(slot_req(OP_ALLOC, 0, 0, 0));
        run_random(200);

        // long receiver hold-off while the sender keeps offering, then a full drain
        hold_go <= 1'b1;
        run_random(30);
        hold_go <= 1'b0;
        wait_drained();

        src_idle_pct = 88;
        snk_idle_pct = 9;
        run_random(200);
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(80);
        wait_drained();

        run_random(100);

        wait_drained();
        repeat (10) @(negedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("** generational_slot_allocator_core: PASSED **");
        end else begin
            $display("** generational_slot_allocator_core: FAILED **");
        end
        $finish;
    end

endmodule
